### sv/msb_first_bit_packer_unit_defines.svh
// Assertion macros of the bit packer RTL, used by the back end.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef MSB_FIRST_BIT_PACKER_UNIT_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mbp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MBP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mbp next-cycle check failed");

`endif

### sv/mbp_pkg.sv
// Shared constants, codes and the job record of the MSB-first bit packer.
// No dependencies; the top level, front end, queue and back end import this package.
package mbp_pkg;

   // Stream capacity and derived widths.
   localparam int MAX_OCTETS  = 64;
   localparam int MAX_RESULTS = 64;
   localparam int CAP_BITS    = MAX_OCTETS * 8;
   localparam int POS_W       = $clog2(CAP_BITS + 1);
   localparam int OCT_W       = $clog2(MAX_OCTETS + 1);
   localparam int FILL_W      = $clog2(MAX_RESULTS + 1);
   localparam int CMP_W       = (OCT_W > FILL_W) ? OCT_W : FILL_W;
   localparam int WIN_W       = 40;
   localparam int WIN_CNT_W   = 3;
   localparam int MAX_INSERT  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SPARE_RESET = 8'h2b;

   // Operation codes of an input beat.
   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_PAD_OCTET  = 2'd1,
      OP_PAD_LENGTH = 2'd2,
      OP_CLEAR      = 2'd3
   } opcode_type;

   // Status codes of a result beat.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_COUNT = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   // One classified operation handed from the front end to the back end.
   typedef struct packed {
      logic [WIN_W-1:0]     bits;        // new bits, aligned under the partial octet
      logic [WIN_CNT_W-1:0] win_octets;  // octets completed from the window
      logic [FILL_W-1:0]    fill_octets; // whole pattern octets after the window
      logic [7:0]           spare;
      logic [1:0]           status;
      logic [9:0]           bit_count;
      logic                 clear;
   } job_type;

endpackage

### sv/mbp_channels_if.sv
// Handshake channel interfaces of the bit packer: request, response and CSR write.
// Depends on no package; widths follow the fixed field widths of the block.
interface mbp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] value;
   logic [5:0]  num_bits;
   logic [6:0]  pad_length;

   modport source (output valid, opcode, value, num_bits, pad_length, input ready);
   modport sink   (input valid, opcode, value, num_bits, pad_length, output ready);
endinterface

interface mbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       last;
   logic [1:0] status;
   logic [9:0] bit_count;

   modport source (output valid, out_byte, byte_valid, last, status, bit_count, input ready);
   modport sink   (input valid, out_byte, byte_valid, last, status, bit_count, output ready);
endinterface

interface mbp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### sv/msb_first_bit_packer_unit.sv
// Top level of the MSB-first bit packer: front end, job queue and back end.
// Depends on mbp_pkg, mbp_channels_if, mbp_front, mbp_queue and mbp_back.
//
//   Channel   Dir   Beat contents
//   req_chan  in    opcode, value, num_bits, pad_length
//   rsp_chan  out   out_byte, byte_valid, last, status, bit_count
//   csr_chan  in    spare pattern octet
//
// The front end takes one request beat per cycle while the two-entry job queue has room.
// The back end loads a job in its idle state, then emits one result beat per free output
// slot; a request that yields no octet still gets a single status-only beat.
// Reset is synchronous: stream empty, partial octet zero, spare pattern 0x2b.
// A stalled response holds the back end; the queue then fills and req_chan.ready drops.
module msb_first_bit_packer_unit (
   input  logic      clock,
   input  logic      reset,
   mbp_req_if.sink   req_chan,
   mbp_rsp_if.source rsp_chan,
   mbp_csr_if.sink   csr_chan
);
   import mbp_pkg::*;

   job_type push_job, head_job;
   logic    push_valid, queue_full, head_valid, pop;

   mbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .push_job   (push_job),
      .push_valid (push_valid),
      .queue_full (queue_full)
   );

   mbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_job   (push_job),
      .push       (push_valid),
      .full       (queue_full),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop        (pop)
   );

   mbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

### sv/mbp_front.sv
// Front end of the bit packer: accepts request beats, tracks stream length and
// classifies each beat into a job. Depends on mbp_pkg and mbp_channels_if.
module mbp_front (
   input  logic             clock,
   input  logic             reset,
   mbp_req_if.sink          req,
   mbp_csr_if.sink          csr,
   output mbp_pkg::job_type push_job,
   output logic             push_valid,
   input  logic             queue_full
);
   import mbp_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         spare_ff, spare_in;
   logic               accept;
   opcode_type         op;
   logic [2:0]         rem;
   logic               rem_nz;
   logic [POS_W:0]     ins_sum;
   logic               ins_bad, ins_over;
   logic [31:0]        ins_mask;
   logic [5:0]         ins_shamt;
   logic [5:0]         ins_total;
   logic [WIN_W-1:0]   ins_bits;
   logic [OCT_W-1:0]   octs_now, target, fill_raw;
   logic               len_over;
   logic [FILL_W-1:0]  room, fill_used;
   logic [OCT_W-1:0]   end_octs;
   logic [POS_W-1:0]   new_pos;
   job_type            job;

   assign accept    = req.valid && req.ready;
   assign req.ready = !queue_full;
   assign csr.ready = 1'b1;
   assign op        = opcode_type'(req.opcode);
   assign rem       = pos_ff[2:0];
   assign rem_nz    = (rem != 3'd0);

   // Insert: range checks and alignment of the new bits below the partial octet.
   assign ins_sum   = {1'b0, pos_ff} + (POS_W + 1)'(req.num_bits);
   assign ins_bad   = (req.num_bits > 6'(MAX_INSERT));
   assign ins_over  = (ins_sum > (POS_W + 1)'(CAP_BITS));
   assign ins_mask  = ~(32'hffff_ffff << req.num_bits);
   assign ins_total = {3'b000, rem} + req.num_bits;
   assign ins_shamt = 6'(WIN_W) - {3'b000, rem} - req.num_bits;
   assign ins_bits  = {8'h00, req.value & ins_mask} << ins_shamt;

   // Octet boundary and pad-to-length target.
   assign octs_now  = OCT_W'(pos_ff >> 3) + OCT_W'(rem_nz);
   assign len_over  = (32'(req.pad_length) > 32'(MAX_OCTETS));
   assign target    = len_over ? OCT_W'(MAX_OCTETS) : OCT_W'(req.pad_length);
   assign fill_raw  = (target > octs_now) ? (target - octs_now) : '0;
   assign room      = FILL_W'(MAX_RESULTS) - FILL_W'(rem_nz);
   assign fill_used = (CMP_W'(fill_raw) > CMP_W'(room)) ? room : FILL_W'(fill_raw);
   assign end_octs  = octs_now + OCT_W'(fill_used);

   // Classify the beat into a job and the stream length after it.
   // At an octet boundary there are no spare bits to merge.
   always_comb begin
      job        = '0;
      job.spare  = spare_ff;
      job.status = STATUS_OK;
      new_pos    = pos_ff;
      unique case (op)
         OP_INSERT: begin
            if (ins_bad) begin
               job.status = STATUS_BAD_COUNT;
            end else if (ins_over) begin
               job.status = STATUS_OVERFLOW;
            end else begin
               job.bits       = ins_bits;
               job.win_octets = ins_total[5:3];
               new_pos        = ins_sum[POS_W-1:0];
            end
         end
         OP_PAD_OCTET: begin
            job.bits       = rem_nz ? {(8'hff >> rem) & spare_ff, 32'h0000_0000} : '0;
            job.win_octets = WIN_CNT_W'(rem_nz);
            new_pos        = {(POS_W - 3)'(octs_now), 3'b000};
         end
         OP_PAD_LENGTH: begin
            job.bits        = rem_nz ? {(8'hff >> rem) & spare_ff, 32'h0000_0000} : '0;
            job.win_octets  = WIN_CNT_W'(rem_nz);
            job.fill_octets = fill_used;
            job.status      = len_over ? STATUS_OVERFLOW : STATUS_OK;
            new_pos         = {(POS_W - 3)'(end_octs), 3'b000};
         end
         OP_CLEAR: begin
            job.clear = 1'b1;
            new_pos   = '0;
         end
         default: begin
            new_pos = pos_ff;
         end
      endcase
      job.bit_count = 10'(new_pos);
   end

   assign push_job   = job;
   assign push_valid = accept;

   // Stream length and pattern register.
   always_comb begin
      pos_in   = accept ? new_pos : pos_ff;
      spare_in = (csr.valid && csr.ready) ? csr.data : spare_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         spare_ff <= SPARE_RESET;
      end else begin
         pos_ff   <= pos_in;
         spare_ff <= spare_in;
      end
   end

endmodule

### sv/mbp_queue.sv
// Short job queue between the front and back ends of the bit packer.
// Depends on mbp_pkg for the job record and the queue depth.
module mbp_queue (
   input  logic             clock,
   input  logic             reset,
   input  mbp_pkg::job_type push_job,
   input  logic             push,
   output logic             full,
   output mbp_pkg::job_type head_job,
   output logic             head_valid,
   input  logic             pop
);
   import mbp_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### sv/mbp_back.sv
// Back end of the bit packer: merges each job with the partial octet and drives
// result beats one per free output slot. Depends on mbp_pkg, mbp_channels_if, defines.
`include "msb_first_bit_packer_unit_defines.svh"

module mbp_back (
   input  logic             clock,
   input  logic             reset,
   input  mbp_pkg::job_type head_job,
   input  logic             head_valid,
   output logic             pop,
   mbp_rsp_if.source        rsp
);
   import mbp_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_EMIT = 2'b10
   } back_state_type;

   back_state_type       state_ff, state_in;
   job_type              job_ff, job_in;
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [WIN_CNT_W-1:0] win_left_ff, win_left_in;
   logic [FILL_W-1:0]    fill_left_ff, fill_left_in;
   logic [7:0]           partial_ff, partial_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_byte_valid_ff, rsp_byte_valid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [9:0]           rsp_count_ff, rsp_count_in;
   logic                 slot_free, load, emit;
   logic                 has_win, has_fill, is_last;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign load      = (state_ff == BK_IDLE) && head_valid;
   assign emit      = (state_ff == BK_EMIT) && slot_free;
   assign pop       = load;
   assign has_win   = (win_left_ff != '0);
   assign has_fill  = (fill_left_ff != '0);
   assign is_last   = has_win ? (!has_fill && win_left_ff == WIN_CNT_W'(1))
                              : (fill_left_ff <= FILL_W'(1));

   // Job sequencing: load a job, then one result beat per free output slot.
   always_comb begin
      state_in          = state_ff;
      job_in            = job_ff;
      window_in         = window_ff;
      win_left_in       = win_left_ff;
      fill_left_in      = fill_left_ff;
      partial_in        = partial_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp.ready;
      rsp_byte_in       = rsp_byte_ff;
      rsp_byte_valid_in = rsp_byte_valid_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_count_in      = rsp_count_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (load) begin
               job_in       = head_job;
               window_in    = {partial_ff, 32'h0000_0000} | head_job.bits;
               win_left_in  = head_job.win_octets;
               fill_left_in = head_job.fill_octets;
               state_in     = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (emit) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = is_last;
               rsp_status_in = job_ff.status;
               rsp_count_in  = job_ff.bit_count;
               priority if (has_win) begin
                  rsp_byte_in       = window_ff[WIN_W-1 -: 8];
                  rsp_byte_valid_in = 1'b1;
                  window_in         = window_ff << 8;
                  win_left_in       = win_left_ff - 1'b1;
               end else if (has_fill) begin
                  rsp_byte_in       = job_ff.spare;
                  rsp_byte_valid_in = 1'b1;
                  fill_left_in      = fill_left_ff - 1'b1;
               end else begin
                  rsp_byte_in       = 8'h00;
                  rsp_byte_valid_in = 1'b0;
               end
               // Unfinished top-of-window bits become the partial octet; a clear zeroes it.
               if (is_last) begin
                  state_in = BK_IDLE;
                  if (job_ff.clear) begin
                     partial_in = 8'h00;
                  end else if (has_win) begin
                     partial_in = window_ff[WIN_W-9 -: 8];
                  end else begin
                     partial_in = window_ff[WIN_W-1 -: 8];
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         partial_ff   <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         partial_ff   <= partial_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Job and output payload registers.
   always_ff @(posedge clock) begin
      job_ff            <= job_in;
      window_ff         <= window_in;
      win_left_ff       <= win_left_in;
      fill_left_ff      <= fill_left_in;
      rsp_byte_ff       <= rsp_byte_in;
      rsp_byte_valid_ff <= rsp_byte_valid_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = rsp_byte_ff;
   assign rsp.byte_valid = rsp_byte_valid_ff;
   assign rsp.last       = rsp_last_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.bit_count  = rsp_count_ff;

   // A job never completes more than four octets from its window.
   `MBP_ASSERT_NOW(a_win_bound, state_ff == BK_EMIT, win_left_ff <= WIN_CNT_W'(4))
   // After the final beat of a job the sequencer is free for the next one.
   `MBP_ASSERT_NEXT(a_last_idle, emit && is_last, state_ff == BK_IDLE)
   // A beat without an octet only occurs as the single beat of its job.
   `MBP_ASSERT_NOW(a_status_last, rsp_valid_ff && !rsp_byte_valid_ff, rsp_last_ff)

endmodule
